>>> hw/rtl/sbaph_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the spectrum bin average / peak hold core.
// No dependencies; imported by sbaph_oq, sbaph_pipe and the top level (not by sbaph_ram).
package sbaph_pkg;

	localparam int BIN_W     = 12;
	localparam int FACTOR_W  = 16;
	localparam int HOLD_W    = 16;
	localparam int DECAY_W   = 12;
	localparam int TICK_W    = 32;
	localparam int DROP_W    = DECAY_W + TICK_W;
	localparam int CFG_IDX_W = 3;

	// pipeline and result queue sizing
	localparam int PIPE_STAGES = 5;
	localparam int STG_CNT_W   = 3;
	localparam int OQ_DEPTH    = 8;
	localparam int OQ_PTR_W    = 3;
	localparam int OQ_CNT_W    = 4;

	// register reset values
	localparam int RESET_FLOOR_DB = -20480;
	localparam int RESET_CEIL_DB  = 0;
	localparam int RESET_FACTOR   = 52429;
	localparam int RESET_HOLD     = 120;
	localparam int RESET_DECAY    = 51;

	localparam int ONE_Q16    = 65536;
	localparam int ROUND_HALF = 32768;

	typedef enum logic [1:0] {
		MODE_NONE = 2'd0,
		MODE_EXP  = 2'd1,
		MODE_LIN  = 2'd2,
		MODE_PEAK = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE   = 3'd0,
		REG_FACTOR = 3'd1,
		REG_FLOOR  = 3'd2,
		REG_CEIL   = 3'd3,
		REG_HOLD   = 3'd4,
		REG_DECAY  = 3'd5
	} reg_idx_t;

	typedef struct packed {
		mode_t               mode;
		logic [FACTOR_W-1:0] smooth;
		logic [HOLD_W-1:0]   hold;
		logic [DECAY_W-1:0]  decay;
	} sbaph_ctl_t;

	typedef struct packed {
		logic                 clearing;
		logic                 hit;
		logic [STG_CNT_W-1:0] busy;
	} sbaph_stat_t;

endpackage

>>> hw/rtl/sbaph_ram.sv
`timescale 1ns / 1ps
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
module sbaph_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

>>> hw/rtl/sbaph_oq.sv
`timescale 1ns / 1ps
// Result queue: eight entry register FIFO in front of the result channel.
// Depends on sbaph_pkg for the queue sizing.
module sbaph_oq #(
	parameter int WIDTH = 44
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic [WIDTH-1:0]               push_data,
	output logic                           valid,
	input  logic                           stall,
	output logic [WIDTH-1:0]               data,
	output logic [sbaph_pkg::OQ_CNT_W-1:0] count
);
	import sbaph_pkg::*;

	logic [WIDTH-1:0]    mem_q [OQ_DEPTH];
	logic [OQ_PTR_W-1:0] wr_ptr_q;
	logic [OQ_PTR_W-1:0] rd_ptr_q;
	logic [OQ_CNT_W-1:0] count_q;
	logic                pop;

	assign valid = (count_q != '0);
	assign pop   = valid && !stall;
	assign data  = mem_q[rd_ptr_q];
	assign count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hw/rtl/sbaph_pipe.sv
`timescale 1ns / 1ps
// Five stage bin datapath: store read, clamp, averaging and peak decay, write back.
// Depends on sbaph_pkg and sbaph_ram; also runs the store clearing sweep after reset.
module sbaph_pipe #(
	parameter int NUM_BINS = 4096,
	parameter int LEVEL_BITS = 16,
	localparam int ADDR_W = $clog2(NUM_BINS)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                issue,
	input  logic [ADDR_W-1:0]                   issue_addr,
	input  logic signed [LEVEL_BITS-1:0]        issue_level,
	input  logic [sbaph_pkg::TICK_W-1:0]        tick,
	input  sbaph_pkg::sbaph_ctl_t               ctl,
	input  logic signed [LEVEL_BITS-1:0]        floor_db,
	input  logic signed [LEVEL_BITS-1:0]        ceil_db,
	output sbaph_pkg::sbaph_stat_t              stat,
	output logic                                res_push,
	output logic [sbaph_pkg::BIN_W-1:0]         res_bin,
	output logic signed [LEVEL_BITS-1:0]        res_shown,
	output logic signed [LEVEL_BITS-1:0]        res_peak
);
	import sbaph_pkg::*;

	localparam int L      = LEVEL_BITS;
	localparam int WORD_W = TICK_W + 2 * L;
	localparam int PA_W   = L + 17;
	localparam int PB_W   = L + 18;
	localparam int SUM_W  = L + 18;
	localparam int MARG_W = L + 1;
	localparam int CMP_W  = DROP_W + 1;
	localparam logic signed [L-1:0] RST_FLOOR = L'(RESET_FLOOR_DB);
	localparam logic [WORD_W-1:0] CLEAR_WORD = {{TICK_W{1'b0}}, RST_FLOOR, RST_FLOOR};
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_BINS - 1);

	// store clearing sweep
	logic              clr_q;
	logic [ADDR_W-1:0] clr_addr_q;

	// store port
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [WORD_W-1:0] ram_wdata;
	logic [WORD_W-1:0] ram_rdata;

	// stage valids
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// stage 1
	logic [ADDR_W-1:0]   addr_s1;
	logic signed [L-1:0] lvl_s1;
	logic [TICK_W-1:0]   tick_s1;
	logic signed [L-1:0] rd_avg, rd_peak, lvl_lo, x_c;
	logic [TICK_W-1:0]   rd_stamp, elapsed_c;

	// stage 2
	logic [ADDR_W-1:0]   addr_s2;
	logic signed [L-1:0] x_s2, avg_s2, peak_s2;
	logic [TICK_W-1:0]   stamp_s2, tick_s2, elapsed_s2;
	logic signed [16:0]  f_s;
	logic [16:0]         g_u;
	logic signed [17:0]  g_s;
	logic signed [PA_W-1:0] prod_a_c;
	logic signed [PB_W-1:0] prod_b_c;
	logic                late_c;
	logic [TICK_W-1:0]   over_c;

	// stage 3
	logic [ADDR_W-1:0]      addr_s3;
	logic signed [L-1:0]    x_s3, avg_s3, peak_s3;
	logic [TICK_W-1:0]      stamp_s3, tick_s3, over_s3;
	logic signed [PA_W-1:0] prod_a_s3;
	logic signed [PB_W-1:0] prod_b_s3;
	logic                   late_s3;
	logic signed [SUM_W-1:0]  rnd_c;
	logic [DROP_W-1:0]        drop_c;
	logic signed [MARG_W-1:0] margin_c;

	// stage 4
	logic [ADDR_W-1:0]        addr_s4;
	logic signed [L-1:0]      x_s4, avg_s4, peak_s4;
	logic [TICK_W-1:0]        stamp_s4, tick_s4;
	logic signed [SUM_W-1:0]  rnd_s4;
	logic [DROP_W-1:0]        drop_s4;
	logic signed [MARG_W-1:0] margin_s4;
	logic                     late_s4;
	logic signed [L-1:0]      avg_new_c, pdec_c;
	logic signed [CMP_W-1:0]  drop_cmp, marg_cmp;
	logic                     under_c;

	// stage 5
	logic [ADDR_W-1:0]   addr_s5;
	logic signed [L-1:0] x_s5, avg_s5, avg_new_s5, peak_s5, pdec_s5;
	logic [TICK_W-1:0]   stamp_s5, tick_s5;
	logic                late_s5, under_s5;
	logic signed [L-1:0] eff_c, shown_c, pk_c;
	logic                newpk_c, wb_we;
	logic [WORD_W-1:0]   wb_data;

	sbaph_ram #(
		.WIDTH (WORD_W),
		.DEPTH (NUM_BINS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (issue_addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == LAST_ADDR) begin
				clr_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage 1: store word arrives, clamp level, time since the peak stamp
	assign rd_avg    = ram_rdata[L-1:0];
	assign rd_peak   = ram_rdata[2*L-1:L];
	assign rd_stamp  = ram_rdata[WORD_W-1:2*L];
	// raise to floor first, then cut to ceiling
	assign lvl_lo    = (lvl_s1 < floor_db) ? floor_db : lvl_s1;
	assign x_c       = (lvl_lo > ceil_db) ? ceil_db : lvl_lo;
	assign elapsed_c = tick_s1 - rd_stamp;

	// stage 2: averaging products, hold test
	assign f_s      = $signed({1'b0, ctl.smooth});
	assign g_u      = 17'(ONE_Q16) - {1'b0, ctl.smooth};
	assign g_s      = $signed({1'b0, g_u});
	assign prod_a_c = f_s * avg_s2;
	assign prod_b_c = g_s * x_s2;
	assign late_c   = elapsed_s2 > TICK_W'(ctl.hold);
	assign over_c   = elapsed_s2 - TICK_W'(ctl.hold);

	// stage 3: sum with rounding bias, decay amount, headroom above floor
	assign rnd_c    = SUM_W'(prod_a_s3) + SUM_W'(prod_b_s3) + SUM_W'(ROUND_HALF);
	assign drop_c   = DROP_W'(ctl.decay) * DROP_W'(over_s3);
	assign margin_c = MARG_W'(peak_s3) - MARG_W'(floor_db);

	// stage 4: new average, decayed peak and whether it falls under the floor
	assign avg_new_c = rnd_s4[L+15:16];
	assign drop_cmp  = $signed({1'b0, drop_s4});
	assign marg_cmp  = CMP_W'(margin_s4);
	assign under_c   = drop_cmp > marg_cmp;
	// only used when not under the floor, so it fits the level width
	assign pdec_c    = peak_s4 - $signed(drop_s4[L-1:0]);

	// stage 5: effective peak, result and write back
	assign eff_c   = !late_s5 ? peak_s5 : (under_s5 ? floor_db : pdec_s5);
	assign newpk_c = x_s5 > eff_c;

	always_comb begin
		shown_c = x_s5;
		pk_c    = floor_db;
		wb_we   = 1'b0;
		wb_data = {stamp_s5, peak_s5, avg_s5};
		case (ctl.mode)
			MODE_EXP: begin
				shown_c = avg_new_s5;
				wb_we   = v_s5;
				wb_data = {stamp_s5, peak_s5, avg_new_s5};
			end
			MODE_PEAK: begin
				pk_c    = newpk_c ? x_s5 : eff_c;
				wb_we   = v_s5 && newpk_c;
				wb_data = {tick_s5, x_s5, avg_s5};
			end
			default: begin
				shown_c = x_s5;
			end
		endcase
	end

	assign ram_we    = clr_q || wb_we;
	assign ram_waddr = clr_q ? clr_addr_q : addr_s5;
	assign ram_wdata = clr_q ? CLEAR_WORD : wb_data;

	always_ff @(posedge clk) begin
		addr_s1 <= issue_addr;
		lvl_s1  <= issue_level;
		tick_s1 <= tick;

		addr_s2    <= addr_s1;
		x_s2       <= x_c;
		avg_s2     <= rd_avg;
		peak_s2    <= rd_peak;
		stamp_s2   <= rd_stamp;
		tick_s2    <= tick_s1;
		elapsed_s2 <= elapsed_c;

		addr_s3   <= addr_s2;
		x_s3      <= x_s2;
		avg_s3    <= avg_s2;
		peak_s3   <= peak_s2;
		stamp_s3  <= stamp_s2;
		tick_s3   <= tick_s2;
		prod_a_s3 <= prod_a_c;
		prod_b_s3 <= prod_b_c;
		late_s3   <= late_c;
		over_s3   <= over_c;

		addr_s4   <= addr_s3;
		x_s4      <= x_s3;
		avg_s4    <= avg_s3;
		peak_s4   <= peak_s3;
		stamp_s4  <= stamp_s3;
		tick_s4   <= tick_s3;
		rnd_s4    <= rnd_c;
		drop_s4   <= drop_c;
		margin_s4 <= margin_c;
		late_s4   <= late_s3;

		addr_s5    <= addr_s4;
		x_s5       <= x_s4;
		avg_s5     <= avg_s4;
		avg_new_s5 <= avg_new_c;
		peak_s5    <= peak_s4;
		stamp_s5   <= stamp_s4;
		tick_s5    <= tick_s4;
		late_s5    <= late_s4;
		under_s5   <= under_c;
		pdec_s5    <= pdec_c;
	end

	// a bin still in flight has not been written back yet
	assign stat.hit = (v_s1 && (addr_s1 == issue_addr)) || (v_s2 && (addr_s2 == issue_addr)) ||
		(v_s3 && (addr_s3 == issue_addr)) || (v_s4 && (addr_s4 == issue_addr)) ||
		(v_s5 && (addr_s5 == issue_addr));
	assign stat.busy     = STG_CNT_W'($countones({v_s1, v_s2, v_s3, v_s4, v_s5}));
	assign stat.clearing = clr_q;

	assign res_push  = v_s5;
	assign res_bin   = BIN_W'(addr_s5);
	assign res_shown = shown_c;
	assign res_peak  = pk_c;

endmodule

>>> hw/rtl/spectrum_bin_average_peak_hold_core.sv
`timescale 1ns / 1ps
// Spectrum bin averaging / peak hold core: top level with registers and flow control.
// Depends on sbaph_pkg, sbaph_pipe (with sbaph_ram) and sbaph_oq.
//
// Usage:
//   Item channel (item_valid / item_stall): cmd 0 carries a bin level, cmd 1 a time tick.
//   A tick only advances the tick counter. A bin at or beyond NUM_BINS is dropped.
//   Result channel (res_valid / res_stall): one result per accepted in-range bin.
//   Config channel (cfg_valid / cfg_ready): cfg_ready is always high; write registers
//   only while no item is in flight.
//   Each result passes the sbaph_pipe stages and then the result queue.
//   Throughput: one item per cycle while item_stall is low. A bin that matches a bin
//   still in flight is held back until the earlier one leaves the pipeline.
//   Reset: registers take their defaults and a sweep writes the floor into every store
//   entry, one per cycle; item_stall is high while the sweep runs.
//   Receiver stall: results collect in an 8 entry queue; bins keep being taken until
//   queued plus in-flight results reach 8, then item_stall rises. Ticks are never held
//   back except by the reset sweep.
module spectrum_bin_average_peak_hold_core #(
	parameter int NUM_BINS = 4096,
	parameter int LEVEL_BITS = 16,
	localparam int CFG_W = (LEVEL_BITS > 16) ? LEVEL_BITS : 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  logic                              cmd,
	input  logic [sbaph_pkg::BIN_W-1:0]       bin_index,
	input  logic signed [LEVEL_BITS-1:0]      level_db,
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [sbaph_pkg::BIN_W-1:0]       out_bin,
	output logic signed [LEVEL_BITS-1:0]      shown_db,
	output logic signed [LEVEL_BITS-1:0]      peak_db,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [sbaph_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]                  cfg_data
);
	import sbaph_pkg::*;

	localparam int ADDR_W = $clog2(NUM_BINS);
	localparam int RES_W  = BIN_W + 2 * LEVEL_BITS;

	mode_t                        mode_q;
	logic [FACTOR_W-1:0]          factor_q;
	logic signed [LEVEL_BITS-1:0] floor_q;
	logic signed [LEVEL_BITS-1:0] ceil_q;
	logic [HOLD_W-1:0]            hold_q;
	logic [DECAY_W-1:0]           decay_q;
	logic [TICK_W-1:0]            tick_q;

	sbaph_ctl_t                   ctl;
	sbaph_stat_t                  stat;
	logic                         in_range;
	logic                         full;
	logic [OQ_CNT_W-1:0]          oq_count;
	logic [OQ_CNT_W-1:0]          occupancy;
	logic                         accept;
	logic                         issue;

	logic                         res_push;
	logic [BIN_W-1:0]             res_bin;
	logic signed [LEVEL_BITS-1:0] res_shown;
	logic signed [LEVEL_BITS-1:0] res_peak;
	logic [RES_W-1:0]             oq_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_EXP;
			factor_q <= FACTOR_W'(RESET_FACTOR);
			floor_q  <= LEVEL_BITS'(RESET_FLOOR_DB);
			ceil_q   <= LEVEL_BITS'(RESET_CEIL_DB);
			hold_q   <= HOLD_W'(RESET_HOLD);
			decay_q  <= DECAY_W'(RESET_DECAY);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MODE:   mode_q   <= mode_t'(cfg_data[1:0]);
				REG_FACTOR: factor_q <= cfg_data[FACTOR_W-1:0];
				REG_FLOOR:  floor_q  <= cfg_data[LEVEL_BITS-1:0];
				REG_CEIL:   ceil_q   <= cfg_data[LEVEL_BITS-1:0];
				REG_HOLD:   hold_q   <= cfg_data[HOLD_W-1:0];
				REG_DECAY:  decay_q  <= cfg_data[DECAY_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign ctl.mode   = mode_q;
	assign ctl.smooth = factor_q;
	assign ctl.hold   = hold_q;
	assign ctl.decay  = decay_q;

	// flow control: every bin in flight holds a queue slot in reserve
	assign in_range   = 32'(bin_index) < 32'(NUM_BINS);
	assign occupancy  = oq_count + OQ_CNT_W'(stat.busy);
	assign full       = occupancy >= OQ_CNT_W'(OQ_DEPTH);
	assign item_stall = stat.clearing || (!cmd && in_range && (stat.hit || full));
	assign accept     = item_valid && !item_stall;
	assign issue      = accept && !cmd && in_range;

	// each bin takes the tick count of its transfer along the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (accept && cmd) begin
			tick_q <= tick_q + 1'b1;
		end
	end

	sbaph_pipe #(
		.NUM_BINS   (NUM_BINS),
		.LEVEL_BITS (LEVEL_BITS)
	) u_pipe (
		.clk         (clk),
		.arst_n      (arst_n),
		.issue       (issue),
		.issue_addr  (ADDR_W'(bin_index)),
		.issue_level (level_db),
		.tick        (tick_q),
		.ctl         (ctl),
		.floor_db    (floor_q),
		.ceil_db     (ceil_q),
		.stat        (stat),
		.res_push    (res_push),
		.res_bin     (res_bin),
		.res_shown   (res_shown),
		.res_peak    (res_peak)
	);

	sbaph_oq #(
		.WIDTH (RES_W)
	) u_oq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data ({res_bin, res_shown, res_peak}),
		.valid     (res_valid),
		.stall     (res_stall),
		.data      (oq_data),
		.count     (oq_count)
	);

	assign out_bin  = oq_data[RES_W-1:2*LEVEL_BITS];
	assign shown_db = oq_data[2*LEVEL_BITS-1:LEVEL_BITS];
	assign peak_db  = oq_data[LEVEL_BITS-1:0];

endmodule
